// ===== hw/rtl/ile_pkg.sv =====
// Package for the indexed list engine.
// Holds the request and status codes, the sequencer states and the
// structs passed between the sequencer and the datapath. No dependencies.
`timescale 1ns / 1ps

package ile_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_READ   = 2'd2,
    CMD_REMOVE = 2'd3
  } ile_cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } ile_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_WALK_UP,
    S_WALK_DN,
    S_RESP
  } ile_state_t;

  // datapath -> sequencer
  typedef struct packed {
    logic fault;   // request rejected (range or full)
    logic is_up;   // insert or append
    logic more;    // another entry to move
    logic pend;    // a moved entry still waits to be written
  } ile_flags_t;

  // sequencer -> datapath
  typedef struct packed {
    logic busy;
    logic load;
    logic fetch;
    logic walk_up;
    logic walk_dn;
    logic done;
    logic resp;
  } ile_ctrl_t;

endpackage

// ===== hw/rtl/ile_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Used as the entry store of the indexed list engine. No dependencies.
`timescale 1ns / 1ps

module ile_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/ile_seq.sv =====
// Sequencer of the indexed list engine: steps one request through
// fetch, entry walk and response. Depends on ile_pkg.
`timescale 1ns / 1ps

module ile_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  ile_pkg::ile_flags_t flags,
  output ile_pkg::ile_ctrl_t  ctrl
);
  import ile_pkg::*;

  ile_state_t state_r;
  ile_state_t state_nxt;
  logic       walk_end;

  assign walk_end = !flags.more && !flags.pend;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (flags.fault) begin
            state_nxt = S_RESP;
          end else if (flags.is_up) begin
            state_nxt = S_WALK_UP;
          end else begin
            state_nxt = S_FETCH;
          end
        end
      end
      S_FETCH:   state_nxt = S_WALK_DN;
      S_WALK_UP: begin
        if (walk_end) begin
          state_nxt = S_RESP;
        end
      end
      S_WALK_DN: begin
        if (walk_end) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP:    state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    case (state_r)
      S_IDLE: begin
        ctrl.load = start;
      end
      S_FETCH: begin
        ctrl.busy  = 1'b1;
        ctrl.fetch = 1'b1;
      end
      S_WALK_UP: begin
        ctrl.busy    = 1'b1;
        ctrl.walk_up = 1'b1;
        ctrl.done    = walk_end;
      end
      S_WALK_DN: begin
        ctrl.busy    = 1'b1;
        ctrl.walk_dn = 1'b1;
        ctrl.done    = walk_end;
      end
      S_RESP: begin
        ctrl.busy = 1'b1;
        ctrl.resp = 1'b1;
      end
      default: ctrl = '0;
    endcase
  end

endmodule

// ===== hw/rtl/indexed_list_engine.sv =====
// Indexed list engine top: request checks, walk index, count and result
// registers around the entry RAM. Depends on ile_pkg, ile_ram and ile_seq.
// A rejected request responds in the cycle after it is taken. Reads and
// removes pass a fetch state first; insert and remove walk the entries
// from position to count, one per cycle through the single RAM port pair.
// One request at a time: busy stays high through the result strobe.
// Synchronous reset empties the list; the entry RAM is not cleared.
`timescale 1ns / 1ps

module indexed_list_engine #(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [6:0]  in_position,
  input  logic [31:0] in_item_value,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [31:0] out_read_value,
  output logic [6:0]  out_entry_count
);
  import ile_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int PW = (CW > 7) ? CW : 7;
  localparam int IW = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;

  ile_ctrl_t  ctrl;
  ile_flags_t flags;

  ile_cmd_t         cmd_r,    cmd_nxt;
  ile_status_t      status_r, status_nxt;
  logic [CW-1:0]    count_r,  count_nxt;
  logic [CW-1:0]    pos_r,    pos_nxt;
  logic [CW-1:0]    idx_r,    idx_nxt;
  logic [AW-1:0]    wa_r,     wa_nxt;
  logic             pend_r,   pend_nxt;
  logic             cap_r,    cap_nxt;
  logic [VALUE_WIDTH-1:0] val_r, val_nxt;
  logic [VALUE_WIDTH-1:0] rv_r,  rv_nxt;

  ile_cmd_t         cmd_in;
  ile_status_t      status_in;
  logic             is_up_in;
  logic [PW-1:0]    pos_ext;
  logic [PW-1:0]    cnt_ext;
  logic [PW-1:0]    pos_eff_ext;
  logic [IW-1:0]    val_in_wide;
  logic [IW-1:0]    rv_wide;
  logic [CW-1:0]    idx_dec;
  logic             more_up;
  logic             more_dn;
  logic             walking;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [VALUE_WIDTH-1:0] ram_wdata;
  logic                   ram_re;
  logic [AW-1:0]          ram_raddr;
  logic [VALUE_WIDTH-1:0] ram_rdata;

  // request check
  always_comb begin
    cmd_in      = ile_cmd_t'(in_command);
    is_up_in    = (cmd_in == CMD_INSERT) || (cmd_in == CMD_APPEND);
    pos_ext     = PW'(in_position);
    cnt_ext     = PW'(count_r);
    pos_eff_ext = (cmd_in == CMD_APPEND) ? cnt_ext : pos_ext;
    val_in_wide = IW'(in_item_value);
    if (is_up_in) begin
      if (pos_eff_ext > cnt_ext) begin
        status_in = ST_RANGE;
      end else if (count_r >= CW'(CAPACITY)) begin
        status_in = ST_FULL;
      end else begin
        status_in = ST_OK;
      end
    end else begin
      status_in = (pos_ext >= cnt_ext) ? ST_RANGE : ST_OK;
    end
  end

  assign idx_dec = idx_r - CW'(1);
  assign more_up = idx_r > pos_r;
  assign more_dn = (idx_r < count_r) && (cmd_r == CMD_REMOVE);
  assign walking = ctrl.walk_up || ctrl.walk_dn;

  assign flags.fault = (status_in != ST_OK);
  assign flags.is_up = is_up_in;
  assign flags.more  = ctrl.walk_up ? more_up : more_dn;
  assign flags.pend  = pend_r;

  ile_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .flags (flags),
    .ctrl  (ctrl)
  );

  // entry store: a moved entry is written in the cycle after its read
  assign ram_we    = pend_r || (ctrl.walk_up && ctrl.done);
  assign ram_waddr = pend_r ? wa_r : pos_r[AW-1:0];
  assign ram_wdata = pend_r ? ram_rdata : val_r;
  assign ram_re    = ctrl.fetch || (walking && flags.more);
  assign ram_raddr = ctrl.walk_up ? idx_dec[AW-1:0] : idx_r[AW-1:0];

  ile_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    cmd_nxt    = cmd_r;
    status_nxt = status_r;
    count_nxt  = count_r;
    pos_nxt    = pos_r;
    idx_nxt    = idx_r;
    wa_nxt     = wa_r;
    pend_nxt   = pend_r;
    cap_nxt    = cap_r;
    val_nxt    = val_r;
    rv_nxt     = rv_r;
    if (ctrl.load) begin
      cmd_nxt    = cmd_in;
      status_nxt = status_in;
      pos_nxt    = pos_eff_ext[CW-1:0];
      idx_nxt    = is_up_in ? count_r : pos_eff_ext[CW-1:0];
      val_nxt    = val_in_wide[VALUE_WIDTH-1:0];
      rv_nxt     = '0;
      pend_nxt   = 1'b0;
      cap_nxt    = 1'b0;
    end
    if (ctrl.fetch) begin
      idx_nxt = idx_r + CW'(1);
      cap_nxt = 1'b1;
    end
    if (ctrl.walk_up) begin
      pend_nxt = more_up;
      if (more_up) begin
        wa_nxt  = idx_r[AW-1:0];
        idx_nxt = idx_dec;
      end
      if (ctrl.done) begin
        count_nxt = count_r + CW'(1);
      end
    end
    if (ctrl.walk_dn) begin
      cap_nxt  = 1'b0;
      pend_nxt = more_dn;
      if (cap_r) begin
        rv_nxt = ram_rdata;
      end
      if (more_dn) begin
        wa_nxt  = idx_dec[AW-1:0];
        idx_nxt = idx_r + CW'(1);
      end
      if (ctrl.done && (cmd_r == CMD_REMOVE)) begin
        count_nxt = count_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      pend_r  <= 1'b0;
      cap_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
      cap_r   <= cap_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    status_r <= status_nxt;
    pos_r    <= pos_nxt;
    idx_r    <= idx_nxt;
    wa_r     <= wa_nxt;
    val_r    <= val_nxt;
    rv_r     <= rv_nxt;
  end

  logic [PW-1:0] count_wide;

  assign count_wide      = PW'(count_r);
  assign rv_wide         = IW'(rv_r);
  assign busy            = ctrl.busy;
  assign out_valid       = ctrl.resp;
  assign out_status      = status_r;
  assign out_read_value  = rv_wide[31:0];
  assign out_entry_count = count_wide[6:0];

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but engine not busy");

  a_fault_quick: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.load && flags.fault) |=> out_valid)
    else $error("rejected request did not respond next cycle");

  a_pend_walk: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> walking)
    else $error("pending entry write outside a walk");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status_r != ST_OK) |-> $stable(count_r))
    else $error("count changed on a rejected request");

endmodule

// ===== tb/indexed_list_engine_test.sv =====
// Self-checking testbench for indexed_list_engine: directed and random insert, append,
// read and remove requests, checked against a list tracker class kept in step with the RTL.
// Depends on ile_pkg and indexed_list_engine.
`timescale 1ns / 1ps

module indexed_list_engine_test;
  import ile_pkg::*;

  localparam int CAPACITY = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int RANDOM_PER_PHASE = 470;
  localparam int BLOCK_LEN = 96;

  typedef enum int {
    BIAS_FILL,
    BIAS_DRAIN,
    BIAS_MIX
  } bias_t;

  typedef struct {
    ile_status_t status;
    logic [31:0] value;
    logic [6:0]  count;
  } list_reply_t;

  class list_tracker;
    logic [31:0] slots [CAPACITY];
    int fill;
    int peak;
    int mismatches;
    int n_ok, n_range, n_full, n_both;
    list_reply_t replies [$];

    function new();
      fill = 0;
      peak = 0;
      mismatches = 0;
      n_ok = 0;
      n_range = 0;
      n_full = 0;
      n_both = 0;
    endfunction

    function void accept_command(ile_cmd_t cmd, logic [6:0] pos, logic [31:0] val);
      list_reply_t r;
      int p;
      r.status = ST_OK;
      r.value = '0;
      p = int'(pos);
      if (cmd == CMD_INSERT || cmd == CMD_APPEND) begin
        if (cmd == CMD_APPEND) p = fill;
        if (p > fill) begin
          r.status = ST_RANGE;
          if (fill >= CAPACITY) n_both++;
        end else if (fill >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (int i = fill; i > p; i--) slots[i] = slots[i-1];
          slots[p] = val;
          fill++;
        end
      end else if (p >= fill) begin
        r.status = ST_RANGE;
      end else begin
        r.value = slots[p];
        if (cmd == CMD_REMOVE) begin
          for (int i = p; i < fill - 1; i++) slots[i] = slots[i+1];
          fill--;
        end
      end
      r.count = 7'(fill);
      if (fill > peak) peak = fill;
      case (r.status)
        ST_OK:    n_ok++;
        ST_RANGE: n_range++;
        default:  n_full++;
      endcase
      replies.push_back(r);
    endfunction

    function void check_response(logic [1:0] st, logic [31:0] v, logic [6:0] c);
      list_reply_t e;
      if (replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result status=%0d value=%h count=%0d", $realtime, st, v, c);
        return;
      end
      e = replies.pop_front();
      if (st !== e.status || v !== e.value || c !== e.count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch: expected status=%0d value=%h count=%0d, got %0d %h %0d",
                   $realtime, e.status, e.value, e.count, st, v, c);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_command = CMD_READ;
  logic [6:0]  in_position = '0;
  logic [31:0] in_item_value = '0;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [31:0] out_read_value;
  logic [6:0]  out_entry_count;

  list_tracker tracker = new();
  int sent = 0;

  indexed_list_engine #(
    .CAPACITY(CAPACITY),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_command(in_command),
    .in_position(in_position),
    .in_item_value(in_item_value),
    .out_valid(out_valid),
    .out_status(out_status),
    .out_read_value(out_read_value),
    .out_entry_count(out_entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #25_000_000;
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1)
      tracker.check_response(out_status, out_read_value, out_entry_count);
  end

  // Leaves start high; the caller then sends again, pauses or drains in the same step.
  task automatic send_command(ile_cmd_t cmd, logic [6:0] pos, logic [31:0] val);
    start <= 1'b1;
    in_command <= cmd;
    in_position <= pos;
    in_item_value <= val;
    do @(posedge clk); while (busy !== 1'b0);
    tracker.accept_command(cmd, pos, val);
    sent++;
  endtask

  task automatic pause(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (tracker.replies.size() != 0);
  endtask

  function automatic ile_cmd_t pick_command(bias_t bias);
    int r;
    r = $urandom_range(0, 99);
    case (bias)
      BIAS_FILL:  return r < 45 ? CMD_INSERT : r < 85 ? CMD_APPEND : r < 95 ? CMD_READ : CMD_REMOVE;
      BIAS_DRAIN: return r < 10 ? CMD_INSERT : r < 15 ? CMD_APPEND : r < 40 ? CMD_READ : CMD_REMOVE;
      default:    return r < 25 ? CMD_INSERT : r < 50 ? CMD_APPEND : r < 75 ? CMD_READ : CMD_REMOVE;
    endcase
  endfunction

  function automatic logic [6:0] pick_position(ile_cmd_t cmd);
    int lim;
    int r;
    lim = (cmd == CMD_INSERT) ? tracker.fill : tracker.fill - 1;
    if (lim < 0) lim = 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 7'($urandom_range(0, lim));
    if (r < 80) return $urandom_range(0, 1) ? 7'd0 : 7'(tracker.fill);
    if (r < 95) return 7'($urandom_range(tracker.fill, 127));
    return 7'd127;
  endfunction

  initial begin
    int idle_pct [4] = '{0, 61, 0, 16};
    bias_t bias;
    ile_cmd_t cmd;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list, bad positions, both ends, middle
    send_command(CMD_READ, 7'd0, 32'h0);
    send_command(CMD_REMOVE, 7'd0, 32'h0);
    send_command(CMD_INSERT, 7'd1, 32'h1111_1111);
    send_command(CMD_INSERT, 7'd127, 32'h2222_2222);
    send_command(CMD_INSERT, 7'd0, 32'h0000_0000);
    send_command(CMD_INSERT, 7'd0, 32'hFFFF_FFFF);
    send_command(CMD_APPEND, 7'd127, 32'hA5A5_A5A5);
    send_command(CMD_INSERT, 7'd1, 32'h5A5A_5A5A);
    send_command(CMD_INSERT, 7'd4, 32'h1234_5678);
    send_command(CMD_READ, 7'd0, 32'hFFFF_FFFF);
    send_command(CMD_READ, 7'd4, 32'h0);
    send_command(CMD_READ, 7'd5, 32'h0);
    send_command(CMD_READ, 7'd127, 32'h0);
    send_command(CMD_REMOVE, 7'd2, 32'h0);
    send_command(CMD_REMOVE, 7'd3, 32'h0);
    send_command(CMD_REMOVE, 7'd127, 32'h0);
    send_command(CMD_REMOVE, 7'd0, 32'h0);
    send_command(CMD_APPEND, 7'd0, 32'h8000_0001);
    send_command(CMD_INSERT, 7'd4, 32'h7FFF_FFFE);
    send_command(CMD_READ, 7'd2, 32'h0);
    drain();

    // random blocks: the first in each phase grows toward full, later ones pick fill, drain or mixed bias at random
    for (int ph = 0; ph < 4; ph++) begin
      bias = BIAS_FILL;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (n % BLOCK_LEN == 0 && n != 0) bias = bias_t'($urandom_range(0, 2));
        cmd = pick_command(bias);
        send_command(cmd, pick_position(cmd), $urandom());
        if ($urandom_range(0, 99) < idle_pct[ph]) pause($urandom_range(1, 40));
      end
      drain();
    end

    repeat (80) @(posedge clk);
    $display("%0d requests: %0d ok, %0d bad position (%0d while full), %0d full; peak count %0d",
             sent, tracker.n_ok, tracker.n_range, tracker.n_both, tracker.n_full, tracker.peak);
    $display("%0d mismatches, %0d results still owed", tracker.mismatches, tracker.replies.size());
    if (tracker.mismatches == 0 && tracker.replies.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
